// ===== design/povwas_pkg.sv =====
// shared constants, types and divide helpers for the pov wheel sequencer
`timescale 1ns / 1ps

package povwas_pkg;

  localparam int ANGLE_STEPS  = 300;
  localparam int IMAGE_BYTES  = 36864;
  localparam int COLUMN_BYTES = 96;

  localparam int COUNT_W   = 16;
  localparam int ADDR_W    = 24;
  localparam int TIME_W    = 24;
  localparam int IMAGE_W   = 8;
  localparam int DISP_W    = 3;
  localparam int OFFCFG_W  = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int TIMER_W   = 25;

  // angle index saturates at ANGLE_STEPS, offsets stay below it
  localparam int ANGLE_W = $clog2(ANGLE_STEPS + 1);
  localparam int OFF_W   = (ANGLE_STEPS > 2) ? $clog2(ANGLE_STEPS) : 1;
  localparam int SUM_W   = ANGLE_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [DISP_W-1:0] DISP_SAME   = 3'd0;
  localparam logic [DISP_W-1:0] DISP_TOGGLE = 3'd4;

  typedef enum logic [1:0] {
    OP_HALL     = 2'd0,
    OP_TICK     = 2'd1,
    OP_OVERFLOW = 2'd2,
    OP_USB      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_HOST    = 2'd0,
    MODE_CYCLE   = 2'd1,
    MODE_DORMANT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    IND_NONE  = 2'd0,
    IND_SLOW  = 2'd1,
    IND_SLEEP = 2'd2
  } indicator_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_CHANGE_TIME = 3'd0,
    REG_IMAGE_COUNT       = 3'd1,
    REG_DISPLAY_MODE      = 3'd2,
    REG_ANGLE_OFFSET      = 3'd3,
    REG_REVERSE_DIRECTION = 3'd4,
    REG_SLEEP_TIME        = 3'd5
  } cfg_reg_t;

  // result field positions in m_tdata
  localparam int FA_LSB      = 0;
  localparam int AP_LSB      = FA_LSB + ADDR_W;
  localparam int DM_LSB      = AP_LSB + COUNT_W;
  localparam int CI_LSB      = DM_LSB + 2;
  localparam int CS_LSB      = CI_LSB + IMAGE_W;
  localparam int IND_LSB     = CS_LSB + 1;
  localparam int M_FIELDS_W  = IND_LSB + 2;
  localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W     = M_DATA_W - M_FIELDS_W;

  // reciprocal constants: round-up multiplier, exact for the full input width
  localparam int     LOG_N  = $clog2(ANGLE_STEPS);
  localparam int     DIV16_K = COUNT_W + LOG_N;
  localparam longint DIV16_M = ((64'd1 << DIV16_K) + ANGLE_STEPS - 1) / ANGLE_STEPS;
  localparam int     DIV9_K  = OFFCFG_W + LOG_N;
  localparam longint DIV9_M  = ((64'd1 << DIV9_K) + ANGLE_STEPS - 1) / ANGLE_STEPS;

  // count / ANGLE_STEPS by reciprocal multiply
  function automatic logic [COUNT_W-1:0] div_steps16(input logic [COUNT_W-1:0] x);
    logic [47:0] prod;
    prod = 48'(x) * 48'(DIV16_M);
    return prod[DIV16_K +: COUNT_W];
  endfunction

  // offset % ANGLE_STEPS for the 9-bit offset register
  function automatic logic [OFF_W-1:0] mod_steps9(input logic [OFFCFG_W-1:0] v);
    logic [31:0]         prod;
    logic [OFFCFG_W-1:0] q;
    logic [OFFCFG_W-1:0] r;
    prod = 32'(v) * 32'(DIV9_M);
    q    = prod[DIV9_K +: OFFCFG_W];
    r    = v - OFFCFG_W'(32'(q) * ANGLE_STEPS);
    return r[OFF_W-1:0];
  endfunction

endpackage

// ===== design/pov_wheel_angle_image_sequencer.sv =====
// pov wheel sequencer: event decode, state update and result register
// results are registered: an input transfer's result is in the output register in the cycle after it
// throughput: one event per cycle; s_tready drops only while a result waits on m_tready
// all state updates and the column address are computed in the accept cycle
// reset (rst, synchronous): usb mode, first-run set, display on, counters and
//   config registers at their defaults, output register empty
`timescale 1ns / 1ps

module pov_wheel_angle_image_sequencer (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_wr_en,
  input  logic [povwas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [povwas_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // event stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [povwas_pkg::COUNT_W-1:0]        s_tdata,   // timer_count[15:0]
  input  logic [1:0]                            s_tuser,   // opcode[1:0]
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // fetch_address[23:0], angle_period[39:24], device_mode[41:40],
  // current_image[49:42], current_side[50], indicator[52:51], zero pad
  output logic [povwas_pkg::M_DATA_W-1:0]       m_tdata,
  output logic [1:0]                            m_tuser    // fetch_valid[0], period_valid[1]
);

  localparam logic [povwas_pkg::ANGLE_W-1:0] LAST_ANGLE =
    povwas_pkg::ANGLE_W'(povwas_pkg::ANGLE_STEPS - 1);
  localparam logic [povwas_pkg::ANGLE_W-1:0] STEPS_A =
    povwas_pkg::ANGLE_W'(povwas_pkg::ANGLE_STEPS);
  localparam logic [povwas_pkg::SUM_W-1:0] STEPS_S =
    povwas_pkg::SUM_W'(povwas_pkg::ANGLE_STEPS);
  localparam logic [povwas_pkg::OFF_W-1:0] LAST_OFF =
    povwas_pkg::OFF_W'(povwas_pkg::ANGLE_STEPS - 1);

  // configuration registers
  logic [povwas_pkg::TIME_W-1:0]   image_change_time;
  logic [povwas_pkg::IMAGE_W-1:0]  image_count;
  logic [povwas_pkg::DISP_W-1:0]   display_mode;
  logic [povwas_pkg::OFF_W-1:0]    offset_mod;
  logic                            reverse_direction;
  logic [povwas_pkg::TIME_W-1:0]   sleep_time;

  // sequencer state
  povwas_pkg::mode_t               mode, mode_next;
  logic                            first_run, first_run_next;
  logic [1:0]                      wake_cnt, wake_cnt_next;
  logic [povwas_pkg::TIMER_W-1:0]  image_timer, image_timer_next;
  logic [povwas_pkg::IMAGE_W-1:0]  image_index, image_index_next;
  logic                            side, side_next;
  logic [povwas_pkg::ANGLE_W-1:0]  angle_index, angle_index_next;
  logic [povwas_pkg::OFF_W-1:0]    offset_angle, offset_angle_next;
  logic                            show, show_next;
  logic [povwas_pkg::COUNT_W-1:0]  inactive_count, inactive_count_next;

  // per-event working values
  povwas_pkg::opcode_t             op;
  logic [povwas_pkg::COUNT_W-1:0]  in_count;
  logic                            accept;
  logic                            do_hall;
  logic                            hall_first;
  logic [povwas_pkg::COUNT_W-1:0]  hall_cnt;
  logic [povwas_pkg::COUNT_W-1:0]  chk_cnt;
  logic [povwas_pkg::TIMER_W-1:0]  timer_base;
  logic [povwas_pkg::TIMER_W-1:0]  timer_sum;
  logic [1:0]                      wake_inc;
  logic [povwas_pkg::IMAGE_W-1:0]  img_limit;
  logic [povwas_pkg::IMAGE_W-1:0]  img_inc;
  logic [povwas_pkg::IMAGE_W-1:0]  img_wrap;
  logic [povwas_pkg::ANGLE_W-1:0]  ai_dec;
  logic [povwas_pkg::ANGLE_W-1:0]  ai_inc;
  logic [povwas_pkg::SUM_W-1:0]    rev_sum;
  logic [povwas_pkg::SUM_W-1:0]    fwd_sum;
  logic [32:0]                     sleep_lhs;

  // result values
  logic                            fetch_valid;
  logic [povwas_pkg::ADDR_W-1:0]   fetch_address;
  logic [povwas_pkg::COUNT_W-1:0]  angle_period;
  logic                            period_valid;
  povwas_pkg::indicator_t          indicator;

  assign op       = povwas_pkg::opcode_t'(s_tuser);
  assign in_count = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // image wraps past the last stored image, zero count acts as one
  assign img_limit = (image_count == '0) ? povwas_pkg::IMAGE_W'(1) : image_count;
  assign img_inc   = image_index + 1'b1;
  assign img_wrap  = (img_inc >= img_limit) ? '0 : img_inc;
  assign wake_inc  = wake_cnt + 1'b1;

  // column walk steps, offsets folded back below ANGLE_STEPS
  assign ai_dec  = angle_index - 1'b1;
  assign ai_inc  = (angle_index < STEPS_A) ? angle_index + 1'b1 : angle_index;
  assign rev_sum = povwas_pkg::SUM_W'(ai_dec) + STEPS_S - povwas_pkg::SUM_W'(offset_mod);
  assign fwd_sum = povwas_pkg::SUM_W'(ai_inc) + povwas_pkg::SUM_W'(offset_mod);

  always_comb begin
    mode_next           = mode;
    first_run_next      = first_run;
    wake_cnt_next       = wake_cnt;
    image_timer_next    = image_timer;
    image_index_next    = image_index;
    side_next           = side;
    angle_index_next    = angle_index;
    offset_angle_next   = offset_angle;
    show_next           = show;
    inactive_count_next = inactive_count;
    fetch_valid         = 1'b0;
    fetch_address       = '0;
    angle_period        = '0;
    period_valid        = 1'b0;
    indicator           = povwas_pkg::IND_NONE;
    chk_cnt             = in_count;
    do_hall             = 1'b0;
    hall_first          = 1'b0;
    hall_cnt            = in_count;
    timer_base          = image_timer;
    timer_sum           = '0;
    sleep_lhs           = '0;

    unique case (op)
      povwas_pkg::OP_HALL: begin
        if (mode == povwas_pkg::MODE_DORMANT) begin
          // three pulses wake the wheel
          if (wake_inc == 2'd3) begin
            wake_cnt_next  = '0;
            first_run_next = 1'b1;
            do_hall        = 1'b1;
          end else begin
            wake_cnt_next = wake_inc;
          end
        end else begin
          do_hall = 1'b1;
        end
      end
      povwas_pkg::OP_TICK: begin
        if (mode == povwas_pkg::MODE_CYCLE) begin
          if (reverse_direction) begin
            if (angle_index == '0) begin
              show_next = 1'b0;
            end else begin
              angle_index_next = ai_dec;
              if (ai_dec > LAST_ANGLE) begin
                show_next = 1'b0;
              end else begin
                show_next = 1'b1;
                offset_angle_next = (rev_sum >= STEPS_S) ?
                  povwas_pkg::OFF_W'(rev_sum - STEPS_S) : povwas_pkg::OFF_W'(rev_sum);
              end
            end
          end else begin
            angle_index_next = ai_inc;
            if (ai_inc > LAST_ANGLE) begin
              show_next = 1'b0;
            end else begin
              show_next = 1'b1;
              offset_angle_next = (fwd_sum >= STEPS_S) ?
                povwas_pkg::OFF_W'(fwd_sum - STEPS_S) : povwas_pkg::OFF_W'(fwd_sum);
            end
          end
        end
      end
      povwas_pkg::OP_OVERFLOW: begin
        if (mode == povwas_pkg::MODE_CYCLE && inactive_count != povwas_pkg::COUNT_MAX) begin
          inactive_count_next = inactive_count + 1'b1;
        end
      end
      povwas_pkg::OP_USB: begin
        mode_next      = povwas_pkg::MODE_HOST;
        first_run_next = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_hall) begin
      hall_first = first_run_next;
      if (hall_first) begin
        // revolution timer restarts, so the count seen is zero
        first_run_next = 1'b0;
        mode_next      = povwas_pkg::MODE_CYCLE;
        timer_base     = '0;
        hall_cnt       = '0;
      end
      if (inactive_count != '0) begin
        // too slow: blank this revolution
        show_next           = 1'b0;
        inactive_count_next = '0;
        indicator           = povwas_pkg::IND_SLOW;
        chk_cnt             = hall_cnt;
        if (hall_first) begin
          image_timer_next = '0;
        end
      end else begin
        timer_sum = timer_base + povwas_pkg::TIMER_W'(hall_cnt);
        if (timer_sum >= povwas_pkg::TIMER_W'(image_change_time)) begin
          image_index_next = img_wrap;
          if (display_mode == povwas_pkg::DISP_TOGGLE) begin
            side_next = ~side;
          end
          image_timer_next = '0;
        end else begin
          image_timer_next = timer_sum;
        end
        if (reverse_direction) begin
          angle_index_next  = LAST_ANGLE;
          offset_angle_next = LAST_OFF - offset_mod;
        end else begin
          angle_index_next  = '0;
          offset_angle_next = offset_mod;
        end
        show_next    = 1'b1;
        angle_period = povwas_pkg::div_steps16(hall_cnt);
        period_valid = 1'b1;
        chk_cnt      = '0;
      end
    end

    if (mode_next == povwas_pkg::MODE_CYCLE) begin
      if (inactive_count_next != '0) begin
        show_next = 1'b0;
      end
      // inactive_count * 65535 + count
      sleep_lhs = 33'({inactive_count_next, 16'h0000}) - 33'(inactive_count_next)
                + 33'(chk_cnt);
      if (sleep_lhs >= 33'(sleep_time)) begin
        mode_next           = povwas_pkg::MODE_DORMANT;
        inactive_count_next = '0;
        show_next           = 1'b0;
        indicator           = povwas_pkg::IND_SLEEP;
      end else if (show_next) begin
        show_next = 1'b0;
        if (display_mode == povwas_pkg::DISP_SAME) begin
          fetch_valid   = 1'b1;
          fetch_address = povwas_pkg::ADDR_W'(
            32'(image_index_next) * povwas_pkg::IMAGE_BYTES +
            32'(offset_angle_next) * povwas_pkg::COLUMN_BYTES);
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_change_time <= povwas_pkg::TIME_W'(9000);
      image_count       <= povwas_pkg::IMAGE_W'(1);
      display_mode      <= povwas_pkg::DISP_SAME;
      offset_mod        <= '0;
      reverse_direction <= 1'b0;
      sleep_time        <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        povwas_pkg::REG_IMAGE_CHANGE_TIME: image_change_time <= cfg_wdata;
        povwas_pkg::REG_IMAGE_COUNT:       image_count <= cfg_wdata[povwas_pkg::IMAGE_W-1:0];
        povwas_pkg::REG_DISPLAY_MODE:      display_mode <= cfg_wdata[povwas_pkg::DISP_W-1:0];
        povwas_pkg::REG_ANGLE_OFFSET:
          offset_mod <= povwas_pkg::mod_steps9(cfg_wdata[povwas_pkg::OFFCFG_W-1:0]);
        povwas_pkg::REG_REVERSE_DIRECTION: reverse_direction <= cfg_wdata[0];
        povwas_pkg::REG_SLEEP_TIME:        sleep_time <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= povwas_pkg::MODE_HOST;
      first_run      <= 1'b1;
      wake_cnt       <= '0;
      image_timer    <= '0;
      image_index    <= '0;
      side           <= 1'b0;
      angle_index    <= '0;
      offset_angle   <= '0;
      show           <= 1'b1;
      inactive_count <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      first_run      <= first_run_next;
      wake_cnt       <= wake_cnt_next;
      image_timer    <= image_timer_next;
      image_index    <= image_index_next;
      side           <= side_next;
      angle_index    <= angle_index_next;
      offset_angle   <= offset_angle_next;
      show           <= show_next;
      inactive_count <= inactive_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{povwas_pkg::M_PAD_W{1'b0}}, indicator, side_next, image_index_next,
                  mode_next, angle_period, fetch_address};
      m_tuser <= {period_valid, fetch_valid};
    end
  end

endmodule

// ===== design/povwas_checker.sv =====
// port-level checks for the pov wheel sequencer, bound to the top level
`timescale 1ns / 1ps

module povwas_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [povwas_pkg::M_DATA_W-1:0]   m_tdata,
  input logic [1:0]                        m_tuser
);

  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // every accepted event shows its result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("result missing one cycle after input transfer");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a column fetch only happens while cycling with no warning
  a_fetch_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[povwas_pkg::DM_LSB +: 2] == povwas_pkg::MODE_CYCLE &&
      m_tdata[povwas_pkg::IND_LSB +: 2] == povwas_pkg::IND_NONE)
    else $error("fetch outside cycling mode or with indicator set");

  // a period update never leaves the wheel in usb mode
  a_period_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[povwas_pkg::DM_LSB +: 2] != povwas_pkg::MODE_HOST)
    else $error("period update reported in usb mode");

endmodule

bind pov_wheel_angle_image_sequencer povwas_checker u_povwas_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
